### hw/rtl/mme_pkg.sv
// Shared types and constants of the matrix multiply engine.
package mme_pkg;

   // Field widths of the request and response words.
   localparam int OP_W    = 2;
   localparam int IDX_W   = 7;
   localparam int ELEM_W  = 16;
   localparam int PROD_W  = 32;
   localparam int SUM_W   = 48;
   localparam int OUT_IDX_W = 6;
   localparam int REQ_W   = 32;
   localparam int RSP_W   = 64;

   // Register file.
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;
   localparam int ROWS_W     = 7;
   localparam int COLS_W     = 7;
   localparam int DEPTH_W    = 8;

   localparam logic [CSR_IDX_W-1:0] REG_ROWS  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_COLS  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DEPTH = 2'd2;

   localparam logic [ROWS_W-1:0]  ROWS_RESET  = 7'd64;
   localparam logic [COLS_W-1:0]  COLS_RESET  = 7'd64;
   localparam logic [DEPTH_W-1:0] DEPTH_RESET = 8'd128;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_WRITE_A = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE_B = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY   = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_ISSUE,
      ST_DRAIN
   } state_type;

   typedef struct packed {
      logic write_a;
      logic write_b;
      logic start;
      logic issue;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic a_wr_ok;
      logic b_wr_ok;
      logic query_ok;
      logic depth_zero;
      logic last_issue;
      logic pipe_busy;
      logic out_free;
   } status_type;

endpackage

### hw/rtl/mme_ctrl.sv
// Controller state machine of the matrix multiply engine.
module mme_ctrl (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [mme_pkg::OP_W-1:0]  req_op,
   input  mme_pkg::status_type       status,
   output mme_pkg::cmd_type          cmd
);
   import mme_pkg::*;

   state_type state_ff;
   state_type state_in;
   logic      accept;

   assign req_tready = (state_ff == ST_IDLE);
   assign accept     = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept && req_op == OP_QUERY && status.query_ok) begin
               state_in = status.depth_zero ? ST_DRAIN : ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            if (status.last_issue) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (!status.pipe_busy && status.out_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      case (state_ff)
         ST_IDLE: begin
            cmd.write_a = accept && req_op == OP_WRITE_A && status.a_wr_ok;
            cmd.write_b = accept && req_op == OP_WRITE_B && status.b_wr_ok;
            cmd.start   = accept && req_op == OP_QUERY && status.query_ok;
         end
         ST_ISSUE: begin
            cmd.issue = 1'b1;
         end
         ST_DRAIN: begin
            cmd.load_out = !status.pipe_busy && status.out_free;
         end
         default: cmd = '0;
      endcase
   end

endmodule

### hw/rtl/mme_datapath.sv
// Datapath of the matrix multiply engine: registers, element stores, MAC and output word.
module mme_datapath #(
   parameter int MAX_ROWS  = 64,
   parameter int MAX_COLS  = 64,
   parameter int MAX_DEPTH = 128
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            csr_write,
   input  logic [mme_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mme_pkg::CSR_DATA_W-1:0]  csr_data,
   input  logic [mme_pkg::IDX_W-1:0]       req_row,
   input  logic [mme_pkg::IDX_W-1:0]       req_col,
   input  logic [mme_pkg::ELEM_W-1:0]      req_value,
   input  mme_pkg::cmd_type                cmd,
   output mme_pkg::status_type             status,
   input  logic                            rsp_tready,
   output logic                            rsp_tvalid,
   output logic [mme_pkg::RSP_W-1:0]       rsp_tdata
);
   import mme_pkg::*;

   localparam int A_DEPTH = MAX_ROWS * MAX_DEPTH;
   localparam int B_DEPTH = MAX_DEPTH * MAX_COLS;
   localparam int AW = (A_DEPTH > 1) ? $clog2(A_DEPTH) : 1;
   localparam int BW = (B_DEPTH > 1) ? $clog2(B_DEPTH) : 1;

   logic [ROWS_W-1:0]  rows_ff;
   logic [COLS_W-1:0]  cols_ff;
   logic [DEPTH_W-1:0] depth_ff;
   logic [DEPTH_W-1:0] k_lim;

   logic [ELEM_W-1:0] a_mem [A_DEPTH];
   logic [ELEM_W-1:0] b_mem [B_DEPTH];

   logic [AW-1:0] a_wr_addr;
   logic [BW-1:0] b_wr_addr;
   logic [AW-1:0] a_base;
   logic [AW-1:0] a_addr_ff;
   logic [BW-1:0] b_addr_ff;
   logic [DEPTH_W-1:0] k_left_ff;

   logic [ELEM_W-1:0]        a_rd_ff;
   logic [ELEM_W-1:0]        b_rd_ff;
   logic                     rd_valid_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     prod_valid_ff;
   logic signed [SUM_W-1:0]  acc_ff;

   logic [OUT_IDX_W-1:0] q_row_ff;
   logic [OUT_IDX_W-1:0] q_col_ff;
   logic                 rsp_valid_ff;
   logic [SUM_W-1:0]     out_sum_ff;
   logic [OUT_IDX_W-1:0] out_row_ff;
   logic [OUT_IDX_W-1:0] out_col_ff;

   // Configuration registers; an index beyond the list is ignored.
   always_ff @(posedge clock) begin
      if (reset) begin
         rows_ff  <= ROWS_RESET;
         cols_ff  <= COLS_RESET;
         depth_ff <= DEPTH_RESET;
      end else if (csr_write) begin
         case (csr_index)
            REG_ROWS:  rows_ff  <= csr_data[ROWS_W-1:0];
            REG_COLS:  cols_ff  <= csr_data[COLS_W-1:0];
            REG_DEPTH: depth_ff <= csr_data;
            default:   ;
         endcase
      end
   end

   assign k_lim = (32'(depth_ff) > MAX_DEPTH) ? DEPTH_W'(MAX_DEPTH) : depth_ff;

   assign a_wr_addr = AW'(32'(req_row) * MAX_DEPTH + 32'(req_col));
   assign b_wr_addr = BW'(32'(req_row) * MAX_COLS + 32'(req_col));
   assign a_base    = AW'(32'(req_row) * MAX_DEPTH);

   assign status.a_wr_ok    = (32'(req_row) < MAX_ROWS) && (32'(req_col) < MAX_DEPTH);
   assign status.b_wr_ok    = (32'(req_row) < MAX_DEPTH) && (32'(req_col) < MAX_COLS);
   assign status.query_ok   = (req_row < rows_ff) && (32'(req_row) < MAX_ROWS)
                            && (req_col < cols_ff) && (32'(req_col) < MAX_COLS);
   assign status.depth_zero = (k_lim == '0);
   assign status.last_issue = (k_left_ff == DEPTH_W'(1));
   assign status.pipe_busy  = rd_valid_ff || prod_valid_ff;
   assign status.out_free   = !rsp_valid_ff || rsp_tready;

   // Element stores: one write port and one registered read port each.
   always_ff @(posedge clock) begin
      if (cmd.write_a) begin
         a_mem[a_wr_addr] <= req_value;
      end
      if (cmd.issue) begin
         a_rd_ff <= a_mem[a_addr_ff];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.write_b) begin
         b_mem[b_wr_addr] <= req_value;
      end
      if (cmd.issue) begin
         b_rd_ff <= b_mem[b_addr_ff];
      end
   end

   // Row m of A is contiguous; column n of B steps by one row of B.
   always_ff @(posedge clock) begin
      if (cmd.start) begin
         a_addr_ff <= a_base;
         b_addr_ff <= BW'(32'(req_col));
         k_left_ff <= k_lim;
         q_row_ff  <= req_row[OUT_IDX_W-1:0];
         q_col_ff  <= req_col[OUT_IDX_W-1:0];
      end else if (cmd.issue) begin
         a_addr_ff <= a_addr_ff + AW'(1);
         b_addr_ff <= b_addr_ff + BW'(MAX_COLS);
         k_left_ff <= k_left_ff - DEPTH_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rd_valid_ff   <= 1'b0;
         prod_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff   <= cmd.issue;
         prod_valid_ff <= rd_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= $signed(a_rd_ff) * $signed(b_rd_ff);
      if (cmd.start) begin
         acc_ff <= '0;
      end else if (prod_valid_ff) begin
         acc_ff <= acc_ff + SUM_W'(prod_ff);
      end
   end

   // Output word register; it holds its word until the receiver takes it.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         out_sum_ff <= acc_ff;
         out_row_ff <= q_row_ff;
         out_col_ff <= q_col_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_W - SUM_W - 2 * OUT_IDX_W)'(0), out_col_ff, out_row_ff, out_sum_ff};

endmodule

### hw/rtl/matrix_multiply_engine_top.sv
// Top level of the matrix multiply engine.
//
// Usage: request words on req_ either write one element of A (row m, column k)
// or of B (row k, column n) into the on-chip stores, or ask for C[m][n], the
// dot product of row m of A and column n of B over depth_in_use terms.
// Writes may follow each other in every cycle. A query in range holds
// req_tready low while it reads one element pair a cycle from the two store
// read ports, K pairs in all, K being the clamped depth; each pair passes the
// store read registers, the product register and the accumulator, the sum is
// then loaded into the output register, and the next request is taken in the
// same cycle that the word appears on rsp_. With a depth of zero nothing is
// read and the query goes straight to loading a sum of zero.
// Out-of-range queries and the unused operation give no word.
// The user is to write registers on csr_ only while the engine is idle;
// the engine does not enforce this, and csr_ready is always high.
// Reset restores the register defaults and empties the pipeline and output
// word; the stores keep their contents and must be written before they are read.
// A stalled receiver holds the output word; the engine still takes writes, and
// a query then finishes and waits until the output register is free.
module matrix_multiply_engine_top #(
   parameter int MAX_ROWS  = 64,
   parameter int MAX_COLS  = 64,
   parameter int MAX_DEPTH = 128
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // [1:0] operation, [8:2] row_index, [15:9] col_index, [31:16] element_value
   input  logic [mme_pkg::REQ_W-1:0]       req_tdata,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // [47:0] dot_sum, [53:48] out_row, [59:54] out_col, [63:60] zero
   output logic [mme_pkg::RSP_W-1:0]       rsp_tdata,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [mme_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [mme_pkg::CSR_DATA_W-1:0]  csr_data
);
   import mme_pkg::*;

   logic [OP_W-1:0]   req_op;
   logic [IDX_W-1:0]  req_row;
   logic [IDX_W-1:0]  req_col;
   logic [ELEM_W-1:0] req_value;
   cmd_type           cmd;
   status_type        status;

   assign req_op    = req_tdata[1:0];
   assign req_row   = req_tdata[8:2];
   assign req_col   = req_tdata[15:9];
   assign req_value = req_tdata[31:16];

   assign csr_ready = 1'b1;

   mme_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_op     (req_op),
      .status     (status),
      .cmd        (cmd)
   );

   mme_datapath #(
      .MAX_ROWS  (MAX_ROWS),
      .MAX_COLS  (MAX_COLS),
      .MAX_DEPTH (MAX_DEPTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .csr_write  (csr_valid && csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .req_row    (req_row),
      .req_col    (req_col),
      .req_value  (req_value),
      .cmd        (cmd),
      .status     (status),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### hw/rtl/mme_checker.sv
// Port-level checks of the matrix multiply engine, bound to its top level.
module mme_checker (
   input logic                       clock,
   input logic                       reset,
   input logic                       req_tvalid,
   input logic                       req_tready,
   input logic [mme_pkg::REQ_W-1:0]  req_tdata,
   input logic                       rsp_tvalid,
   input logic                       rsp_tready,
   input logic [mme_pkg::RSP_W-1:0]  rsp_tdata
);
   import mme_pkg::*;

   // A stalled output word stays offered.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("output word dropped while stalled");

   // A stalled output word keeps its value.
   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> $stable(rsp_tdata))
      else $error("output word changed while stalled");

   // Only an accepted query makes the engine busy.
   a_busy_query: assert property (@(posedge clock) disable iff (reset)
      $fell(req_tready) |-> $past(req_tvalid) && $past(req_tdata[1:0]) == OP_QUERY)
      else $error("engine went busy without a query");

   // A new word is issued only as the engine returns to accepting requests.
   a_word_ready: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> req_tready)
      else $error("output word issued while engine busy");

endmodule

bind matrix_multiply_engine_top mme_checker u_mme_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tdata  (req_tdata),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### bench/testbench.sv
// Self-checking bench for the matrix multiply engine: stores, dot-product queries and sizes.
module testbench;
   import mme_pkg::*;

   localparam int ROWS_CAP     = 64;
   localparam int COLS_CAP     = 64;
   localparam int DEPTH_CAP    = 128;
   localparam int DRAIN_CYCLES = DEPTH_CAP + 12;
   localparam int LIMIT_CYCLES = 1_000_000;

   localparam logic [OP_W-1:0]      OP_UNUSED = 2'd3;
   localparam logic [CSR_IDX_W-1:0] REG_SPARE = 2'd3;

   typedef struct packed {
      logic [SUM_W-1:0]     sum;
      logic [OUT_IDX_W-1:0] row;
      logic [OUT_IDX_W-1:0] col;
   } dot_result_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_W-1:0]      req_tdata = '0;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_W-1:0]      rsp_tdata;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // Mirror of the engine: element stores and size registers.
   logic [ELEM_W-1:0]  a_elems [ROWS_CAP*DEPTH_CAP];
   logic [ELEM_W-1:0]  b_elems [DEPTH_CAP*COLS_CAP];
   logic [ROWS_W-1:0]  cfg_rows  = ROWS_RESET;
   logic [COLS_W-1:0]  cfg_cols  = COLS_RESET;
   logic [DEPTH_W-1:0] cfg_depth = DEPTH_RESET;

   // Entries that the request queue will have written by the time it drains.
   bit a_known [ROWS_CAP*DEPTH_CAP];
   bit b_known [DEPTH_CAP*COLS_CAP];

   logic [REQ_W-1:0] request_queue [$];
   dot_result_type   awaited_sums [$];

   int failures = 0;
   int sums_checked = 0;
   int words_sent = 0;
   int settings_used = 1;
   int gap_left = 0;
   int stall_left = 0;
   int stall_draw;
   bit drive_steady = 1'b0;
   bit sink_steady = 1'b0;

   matrix_multiply_engine_top #(
      .MAX_ROWS(ROWS_CAP),
      .MAX_COLS(COLS_CAP),
      .MAX_DEPTH(DEPTH_CAP)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always #1 clock = ~clock;

   function automatic int clamp_cap(input int value, input int cap);
      return (value > cap) ? cap : value;
   endfunction

   // Applies one accepted request word to the mirror and records the dot product it owes.
   function automatic void compute_request(input logic [REQ_W-1:0] word);
      logic [OP_W-1:0]    op;
      logic [IDX_W-1:0]   row;
      logic [IDX_W-1:0]   col;
      logic [ELEM_W-1:0]  value;
      logic signed [SUM_W-1:0]  acc;
      logic signed [PROD_W-1:0] prod;
      dot_result_type res;
      int k;
      op = word[1:0];
      row = word[8:2];
      col = word[15:9];
      value = word[31:16];
      case (op)
         OP_WRITE_A: begin
            if (row < ROWS_CAP) a_elems[row * DEPTH_CAP + col] = value;
         end
         OP_WRITE_B: begin
            if (col < COLS_CAP) b_elems[row * COLS_CAP + col] = value;
         end
         OP_QUERY: begin
            if (row < clamp_cap(cfg_rows, ROWS_CAP) && col < clamp_cap(cfg_cols, COLS_CAP)) begin
               acc = '0;
               for (k = 0; k < clamp_cap(cfg_depth, DEPTH_CAP); k++) begin
                  prod = $signed(a_elems[row * DEPTH_CAP + k]) *
                         $signed(b_elems[k * COLS_CAP + col]);
                  acc = acc + prod;
               end
               res.sum = acc;
               res.row = row[OUT_IDX_W-1:0];
               res.col = col[OUT_IDX_W-1:0];
               awaited_sums.push_back(res);
            end
         end
         default: ;
      endcase
   endfunction

   function automatic void apply_register(input logic [CSR_IDX_W-1:0] index,
                                          input logic [CSR_DATA_W-1:0] value);
      case (index)
         REG_ROWS:  cfg_rows = value[ROWS_W-1:0];
         REG_COLS:  cfg_cols = value[COLS_W-1:0];
         REG_DEPTH: cfg_depth = value[DEPTH_W-1:0];
         default: ;
      endcase
   endfunction

   // Request driver: one word in flight, a random gap after each, with steady stretches.
   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         gap_left <= 0;
      end else begin
         if (req_tvalid && req_tready) begin
            compute_request(req_tdata);
            words_sent++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left != 0) begin
               gap_left <= gap_left - 1;
               req_tvalid <= 1'b0;
            end else if (request_queue.size() != 0) begin
               req_tdata <= request_queue.pop_front();
               req_tvalid <= 1'b1;
               if ($urandom_range(0, 31) == 0) drive_steady = !drive_steady;
               gap_left <= drive_steady ? 0 : $urandom_range(0, 10);
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each word against the oldest awaited sum, then stalls at random.
   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
         stall_left <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         if (awaited_sums.size() == 0) begin
            failures++;
            $display("%0t: unexpected result word, expected none, got %h", $time, rsp_tdata);
         end else begin
            dot_result_type want;
            want = awaited_sums.pop_front();
            sums_checked++;
            if (rsp_tdata[47:0] !== want.sum) begin
               failures++;
               $display("%0t: dot_sum of C[%0d][%0d] expected %h, got %h",
                        $time, want.row, want.col, want.sum, rsp_tdata[47:0]);
            end
            if (rsp_tdata[53:48] !== want.row) begin
               failures++;
               $display("%0t: out_row expected %0d, got %0d", $time, want.row, rsp_tdata[53:48]);
            end
            if (rsp_tdata[59:54] !== want.col) begin
               failures++;
               $display("%0t: out_col expected %0d, got %0d", $time, want.col, rsp_tdata[59:54]);
            end
         end
         if ($urandom_range(0, 15) == 0) sink_steady = !sink_steady;
         stall_draw = sink_steady ? 0 : $urandom_range(0, 10);
         stall_left <= stall_draw;
         rsp_tready <= (stall_draw == 0);
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_tready <= (stall_left == 1);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   function automatic logic [ELEM_W-1:0] draw_element();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return ELEM_W'($urandom);
      endcase
   endfunction

   task automatic queue_request(input logic [OP_W-1:0] op, input int row, input int col,
                                input logic [ELEM_W-1:0] value);
      request_queue.push_back({value, IDX_W'(col), IDX_W'(row), op});
      if (op == OP_WRITE_A && row < ROWS_CAP) a_known[row * DEPTH_CAP + col] = 1'b1;
      if (op == OP_WRITE_B && col < COLS_CAP) b_known[row * COLS_CAP + col] = 1'b1;
   endtask

   // A query is preceded by writes of whatever row of A or column of B it would read unwritten.
   task automatic queue_query(input int m, input int n, inout int count);
      int k;
      for (k = 0; k < clamp_cap(cfg_depth, DEPTH_CAP); k++) begin
         if (!a_known[m * DEPTH_CAP + k]) begin
            queue_request(OP_WRITE_A, m, k, draw_element());
            count++;
         end
         if (!b_known[k * COLS_CAP + n]) begin
            queue_request(OP_WRITE_B, k, n, draw_element());
            count++;
         end
      end
      queue_request(OP_QUERY, m, n, ELEM_W'($urandom));
      count++;
   endtask

   task automatic run_random_phase(input int target);
      int done;
      int m_lim;
      int n_lim;
      int k_lim;
      int pick;
      int m;
      int n;
      int k;
      int extra;
      done = 0;
      m_lim = clamp_cap(cfg_rows, ROWS_CAP);
      n_lim = clamp_cap(cfg_cols, COLS_CAP);
      k_lim = clamp_cap(cfg_depth, DEPTH_CAP);
      while (done < target) begin
         pick = $urandom_range(0, 99);
         if (pick < 70 && m_lim > 0 && n_lim > 0) begin
            // Mostly a few low rows and columns, so that deep queries reuse written data.
            m = ($urandom_range(0, 3) == 0) ? $urandom_range(0, m_lim - 1)
                                            : $urandom_range(0, clamp_cap(m_lim, 4) - 1);
            n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, n_lim - 1)
                                            : $urandom_range(0, clamp_cap(n_lim, 4) - 1);
            if ($urandom_range(0, 1) == 1) begin
               for (extra = $urandom_range(1, 3); extra > 0; extra--) begin
                  k = (k_lim > 0) ? $urandom_range(0, k_lim - 1)
                                  : $urandom_range(0, DEPTH_CAP - 1);
                  if ($urandom_range(0, 1) == 1) queue_request(OP_WRITE_A, m, k, draw_element());
                  else queue_request(OP_WRITE_B, k, n, draw_element());
                  done++;
               end
            end
            queue_query(m, n, done);
         end else if (pick < 85 || (pick < 70)) begin
            if ($urandom_range(0, 1) == 1)
               queue_request(OP_WRITE_A, $urandom_range(0, ROWS_CAP - 1),
                             $urandom_range(0, DEPTH_CAP - 1), draw_element());
            else
               queue_request(OP_WRITE_B, $urandom_range(0, DEPTH_CAP - 1),
                             $urandom_range(0, COLS_CAP - 1), draw_element());
            done++;
         end else begin
            case ($urandom_range(0, 3))
               0: queue_request(OP_UNUSED, $urandom_range(0, 127), $urandom_range(0, 127),
                                ELEM_W'($urandom));
               1: queue_request(OP_WRITE_A, $urandom_range(ROWS_CAP, 127),
                                $urandom_range(0, 127), draw_element());
               2: queue_request(OP_WRITE_B, $urandom_range(0, 127),
                                $urandom_range(COLS_CAP, 127), draw_element());
               default: begin
                  if ($urandom_range(0, 1) == 1)
                     queue_request(OP_QUERY, $urandom_range(m_lim, 127),
                                   $urandom_range(0, 127), ELEM_W'($urandom));
                  else
                     queue_request(OP_QUERY, $urandom_range(0, 127),
                                   $urandom_range(n_lim, 127), ELEM_W'($urandom));
               end
            endcase
         end
      end
   endtask

   // Waits for the queue and the outstanding sums to empty, then lets a late query finish.
   task automatic settle();
      while (request_queue.size() != 0 || req_tvalid || awaited_sums.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Called at a rising edge; returns at the edge that took the word.
   task automatic csr_write(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      apply_register(index, value);
   endtask

   task automatic set_dims(input logic [CSR_DATA_W-1:0] rows, input logic [CSR_DATA_W-1:0] cols,
                           input logic [CSR_DATA_W-1:0] depth, input bit with_spare);
      @(posedge clock);
      csr_write(REG_ROWS, rows);
      csr_write(REG_COLS, cols);
      csr_write(REG_DEPTH, depth);
      if (with_spare) csr_write(REG_SPARE, CSR_DATA_W'($urandom));
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   task automatic run_phase(input logic [CSR_DATA_W-1:0] rows, input logic [CSR_DATA_W-1:0] cols,
                            input logic [CSR_DATA_W-1:0] depth, input int target,
                            input bit with_spare);
      set_dims(rows, cols, depth, with_spare);
      @(negedge clock);
      run_random_phase(target);
      settle();
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Reset sizes first: full depth, so the first queries fill whole rows and columns.
      @(negedge clock);
      run_random_phase(200);
      settle();

      // Extremes of the element values and indices at a depth of two.
      set_dims(8'd64, 8'd64, 8'd2, 1'b0);
      @(negedge clock);
      queue_request(OP_WRITE_A, 0, 0, 16'h7FFF);
      queue_request(OP_WRITE_A, 0, 1, 16'h8000);
      queue_request(OP_WRITE_B, 0, 0, 16'h8000);
      queue_request(OP_WRITE_B, 1, 0, 16'h7FFF);
      queue_request(OP_WRITE_A, 63, 0, 16'hFFFF);
      queue_request(OP_WRITE_A, 63, 1, 16'h0100);
      queue_request(OP_WRITE_B, 0, 63, 16'h8000);
      queue_request(OP_WRITE_B, 1, 63, 16'hFFFF);
      queue_request(OP_WRITE_A, 0, 127, 16'h5A5A);
      queue_request(OP_WRITE_B, 127, 0, 16'hA5A5);
      // Writes outside the stores must leave them untouched.
      queue_request(OP_WRITE_A, 127, 127, 16'h1234);
      queue_request(OP_WRITE_A, 64, 0, 16'h4321);
      queue_request(OP_WRITE_B, 0, 64, 16'h7777);
      queue_request(OP_WRITE_B, 127, 127, 16'h8888);
      queue_request(OP_QUERY, 0, 0, 16'hFFFF);
      queue_request(OP_QUERY, 63, 63, 16'h0000);
      queue_request(OP_QUERY, 0, 63, 16'h8000);
      queue_request(OP_QUERY, 63, 0, 16'h7FFF);
      // Queries outside the sizes and the unused operation give no word.
      queue_request(OP_QUERY, 64, 0, 16'h0000);
      queue_request(OP_QUERY, 0, 64, 16'h0000);
      queue_request(OP_QUERY, 127, 127, 16'hFFFF);
      queue_request(OP_UNUSED, 0, 0, 16'h0000);
      queue_request(OP_UNUSED, 127, 127, 16'hFFFF);
      settle();

      run_phase(8'd8, 8'd8, 8'd8, 400, 1'b0);
      run_phase(8'd1, 8'd1, 8'd1, 100, 1'b0);
      // Only the top bit set: the row count reads as zero.
      run_phase(8'h80, 8'd5, 8'd4, 60, 1'b0);
      run_phase(8'd5, 8'd0, 8'd4, 60, 1'b0);
      run_phase(8'd6, 8'd7, 8'd0, 150, 1'b0);
      // Values above capacity saturate at the store sizes.
      run_phase(8'd127, 8'hC8, 8'd255, 250, 1'b1);
      run_phase(8'd64, 8'd64, 8'd128, 200, 1'b0);
      run_phase(8'd3, 8'd5, 8'd17, 100, 1'b0);
      run_phase(8'd16, 8'd2, 8'd33, 100, 1'b0);
      run_phase(8'd2, 8'd16, 8'd64, 100, 1'b0);
      run_phase(8'd13, 8'd11, 8'd100, 100, 1'b0);

      $display("Sent %0d request words under %0d size settings, with random stalls on both sides;",
               words_sent, settings_used);
      $display("checked %0d dot products, %0d mismatches.", sums_checked, failures);
      if (failures == 0) begin
         $display("PASS matrix_multiply_engine_top");
      end else begin
         $display("FAIL matrix_multiply_engine_top");
      end
      $finish;
   end

   initial begin
      #(2 * LIMIT_CYCLES);
      $display("Run did not finish in time: %0d sums still awaited.", awaited_sums.size());
      $display("FAIL matrix_multiply_engine_top");
      $finish;
   end

endmodule
